// ===== hw/rtl/art_pkg.sv =====
package art_pkg;

  localparam int unsigned EntriesDef  = 16;
  localparam int unsigned AddrBitsDef = 48;
  localparam int unsigned TagBits     = 16;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_e;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic do_insert;
    logic do_remove;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/art_cell.sv =====
module art_cell #(
  parameter int unsigned AddrBits = art_pkg::AddrBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  art_pkg::cell_ctrl_t         ctrl_i,
  input  logic [AddrBits:0]           key_i,
  input  logic [AddrBits-1:0]         new_start_i,
  input  logic [AddrBits:0]           new_end_i,
  input  logic [art_pkg::TagBits-1:0] new_tag_i,
  input  logic                        low_valid_i,
  input  logic                        low_gt_i,
  input  logic [AddrBits-1:0]         low_start_i,
  input  logic [AddrBits:0]           low_end_i,
  input  logic [art_pkg::TagBits-1:0] low_tag_i,
  input  logic                        up_valid_i,
  input  logic [AddrBits-1:0]         up_start_i,
  input  logic [AddrBits:0]           up_end_i,
  input  logic [art_pkg::TagBits-1:0] up_tag_i,
  output logic                        valid_o,
  output logic                        gt_o,
  output logic                        eq_o,
  output logic [AddrBits-1:0]         start_o,
  output logic [AddrBits:0]           end_o,
  output logic [art_pkg::TagBits-1:0] tag_o
);
  import art_pkg::*;

  logic                valid_q, valid_d;
  logic [AddrBits-1:0] start_q, start_d;
  logic [AddrBits:0]   end_q, end_d;
  logic [TagBits-1:0]  tag_q, tag_d;

  assign gt_o    = valid_q && (end_q > key_i);
  assign eq_o    = valid_q && (end_q == key_i);
  assign valid_o = valid_q;
  assign start_o = start_q;
  assign end_o   = end_q;
  assign tag_o   = tag_q;

  always_comb begin
    valid_d = valid_q;
    start_d = start_q;
    end_d   = end_q;
    tag_d   = tag_q;
    if (ctrl_i.do_insert) begin
      // larger ends move up one place, the new entry lands in the gap
      if (low_valid_i && low_gt_i) begin
        valid_d = 1'b1;
        start_d = low_start_i;
        end_d   = low_end_i;
        tag_d   = low_tag_i;
      end else if (low_valid_i && (!valid_q || gt_o)) begin
        valid_d = 1'b1;
        start_d = new_start_i;
        end_d   = new_end_i;
        tag_d   = new_tag_i;
      end
    end else if (ctrl_i.do_remove && gt_o) begin
      // selected entry and everything above it move down one place
      valid_d = up_valid_i;
      start_d = up_start_i;
      end_d   = up_end_i;
      tag_d   = up_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    end_q   <= end_d;
    tag_q   <= tag_d;
  end

endmodule

// ===== hw/rtl/art_select.sv =====
module art_select #(
  parameter int unsigned Entries  = art_pkg::EntriesDef,
  parameter int unsigned AddrBits = art_pkg::AddrBitsDef
) (
  input  logic [Entries-1:0]          gt_i,
  input  logic [AddrBits-1:0]         start_i [Entries],
  input  logic [AddrBits:0]           end_i   [Entries],
  input  logic [art_pkg::TagBits-1:0] tag_i   [Entries],
  output logic [Entries-1:0]          onehot_o,
  output logic                        any_o,
  output logic [AddrBits-1:0]         start_o,
  output logic [AddrBits:0]           end_o,
  output logic [art_pkg::TagBits-1:0] tag_o
);
  import art_pkg::*;

  // cells are sorted by end, so the first cell above the key has a neighbor below it that is not
  always_comb begin
    onehot_o[0] = gt_i[0];
    for (int unsigned k = 1; k < Entries; k++) begin
      onehot_o[k] = gt_i[k] && !gt_i[k-1];
    end
  end

  assign any_o = |gt_i;

  always_comb begin
    start_o = '0;
    end_o   = '0;
    tag_o   = '0;
    for (int unsigned k = 0; k < Entries; k++) begin
      start_o = start_o | (start_i[k] & {AddrBits{onehot_o[k]}});
      end_o   = end_o   | (end_i[k]   & {(AddrBits+1){onehot_o[k]}});
      tag_o   = tag_o   | (tag_i[k]   & {TagBits{onehot_o[k]}});
    end
  end

endmodule

// ===== hw/rtl/address_region_table.sv =====
// channel | direction | handshake                | payload
// in      | input     | in_valid_i / in_ready_o  | func_i, address_i, region_size_i, object_tag_i
// out     | output    | out_valid_o / out_ready_i| status_o, found_tag_o, found_start_o, found_end_o
//
// each transaction first registers the command; then every cell compares its end against
// the key in parallel, and the chain shifts by one place on an executed insert or remove
// a command is executed only once the output register is free or being emptied
// reset clears all valid bits in the cells and the control state; no clearing pass
// a stalled output holds the command register, so the input stalls after one transaction
module address_region_table #(
  parameter int unsigned ENTRIES   = art_pkg::EntriesDef,
  parameter int unsigned ADDR_BITS = art_pkg::AddrBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  func_i,
  input  logic [ADDR_BITS-1:0]        address_i,
  input  logic [ADDR_BITS-1:0]        region_size_i,
  input  logic [art_pkg::TagBits-1:0] object_tag_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [1:0]                  status_o,
  output logic [art_pkg::TagBits-1:0] found_tag_o,
  output logic [ADDR_BITS-1:0]        found_start_o,
  output logic [ADDR_BITS:0]          found_end_o
);
  import art_pkg::*;

  // command register
  logic                 busy_q;
  logic [1:0]           func_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [ADDR_BITS-1:0] size_q;
  logic [TagBits-1:0]   tag_q;

  // output register
  logic                 out_valid_q;
  logic [1:0]           status_q, status_d;
  logic [TagBits-1:0]   ftag_q, ftag_d;
  logic [ADDR_BITS-1:0] fstart_q, fstart_d;
  logic [ADDR_BITS:0]   fend_q, fend_d;

  // chain wiring
  logic [ENTRIES-1:0]   cell_valid;
  logic [ENTRIES-1:0]   cell_gt;
  logic [ENTRIES-1:0]   cell_eq;
  logic [ADDR_BITS-1:0] cell_start [ENTRIES];
  logic [ADDR_BITS:0]   cell_end   [ENTRIES];
  logic [TagBits-1:0]   cell_tag   [ENTRIES];

  logic [ENTRIES-1:0]   sel_onehot;
  logic                 sel_any;
  logic [ADDR_BITS-1:0] sel_start;
  logic [ADDR_BITS:0]   sel_end;
  logic [TagBits-1:0]   sel_tag;

  logic [ADDR_BITS:0]   new_end;
  logic [ADDR_BITS:0]   key;
  logic                 fire;
  logic                 dup;
  logic                 full;
  logic                 hit;
  cell_ctrl_t           ctrl;

  assign in_ready_o = !busy_q;
  assign fire       = busy_q && (!out_valid_q || out_ready_i);

  // end is the full sum, one bit wider than an address
  assign new_end = {1'b0, addr_q} + {1'b0, size_q};
  // inserts search by their own end, lookups and removes by the address
  assign key     = (func_q == FUNC_INSERT) ? new_end : {1'b0, addr_q};

  assign dup  = |cell_eq;
  assign full = cell_valid[ENTRIES-1];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    logic                 low_valid;
    logic                 low_gt;
    logic [ADDR_BITS-1:0] low_start;
    logic [ADDR_BITS:0]   low_end;
    logic [TagBits-1:0]   low_tag;
    logic                 up_valid;
    logic [ADDR_BITS-1:0] up_start;
    logic [ADDR_BITS:0]   up_end;
    logic [TagBits-1:0]   up_tag;

    if (k == 0) begin : g_bottom
      // below the first cell sits a valid entry that is never above the key
      assign low_valid = 1'b1;
      assign low_gt    = 1'b0;
      assign low_start = '0;
      assign low_end   = '0;
      assign low_tag   = '0;
    end else begin : g_low
      assign low_valid = cell_valid[k-1];
      assign low_gt    = cell_gt[k-1];
      assign low_start = cell_start[k-1];
      assign low_end   = cell_end[k-1];
      assign low_tag   = cell_tag[k-1];
    end

    if (k == ENTRIES - 1) begin : g_top
      // an empty entry shifts into the last cell on removal
      assign up_valid = 1'b0;
      assign up_start = '0;
      assign up_end   = '0;
      assign up_tag   = '0;
    end else begin : g_up
      assign up_valid = cell_valid[k+1];
      assign up_start = cell_start[k+1];
      assign up_end   = cell_end[k+1];
      assign up_tag   = cell_tag[k+1];
    end

    art_cell #(
      .AddrBits (ADDR_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .key_i       (key),
      .new_start_i (addr_q),
      .new_end_i   (new_end),
      .new_tag_i   (tag_q),
      .low_valid_i (low_valid),
      .low_gt_i    (low_gt),
      .low_start_i (low_start),
      .low_end_i   (low_end),
      .low_tag_i   (low_tag),
      .up_valid_i  (up_valid),
      .up_start_i  (up_start),
      .up_end_i    (up_end),
      .up_tag_i    (up_tag),
      .valid_o     (cell_valid[k]),
      .gt_o        (cell_gt[k]),
      .eq_o        (cell_eq[k]),
      .start_o     (cell_start[k]),
      .end_o       (cell_end[k]),
      .tag_o       (cell_tag[k])
    );
  end

  // smallest end above the key: first cell whose compare is set
  art_select #(
    .Entries  (ENTRIES),
    .AddrBits (ADDR_BITS)
  ) u_select (
    .gt_i     (cell_gt),
    .start_i  (cell_start),
    .end_i    (cell_end),
    .tag_i    (cell_tag),
    .onehot_o (sel_onehot),
    .any_o    (sel_any),
    .start_o  (sel_start),
    .end_o    (sel_end),
    .tag_o    (sel_tag)
  );

  // decode the registered command
  always_comb begin
    ctrl     = '0;
    hit      = 1'b0;
    status_d = STATUS_MISS;
    ftag_d   = '0;
    fstart_d = '0;
    fend_d   = '0;
    case (func_q)
      FUNC_INSERT: begin
        // a duplicate end wins over a full table
        if (dup) begin
          status_d = STATUS_MISS;
        end else if (full) begin
          status_d = STATUS_FULL;
        end else begin
          status_d       = STATUS_OK;
          ctrl.do_insert = fire;
        end
      end
      FUNC_LOOKUP: begin
        hit = sel_any && (addr_q >= sel_start);
      end
      FUNC_REMOVE: begin
        // removal only by the exact start of the region
        hit            = sel_any && (addr_q == sel_start);
        ctrl.do_remove = fire && hit;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    if (hit) begin
      status_d = STATUS_OK;
      ftag_d   = sel_tag;
      fstart_d = sel_start;
      fend_d   = sel_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        busy_q <= 1'b1;
      end else if (fire) begin
        busy_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i;
      addr_q <= address_i;
      size_q <= region_size_i;
      tag_q  <= object_tag_i;
    end
    if (fire) begin
      status_q <= status_d;
      ftag_q   <= ftag_d;
      fstart_q <= fstart_d;
      fend_q   <= fend_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign found_tag_o   = ftag_q;
  assign found_start_o = fstart_q;
  assign found_end_o   = fend_q;

  // valid cells always form one block starting at cell zero
  a_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid + ENTRIES'(1)) & cell_valid) == '0)
    else $error("valid cells are not packed at the bottom of the chain");

  // at most one cell is selected for any key
  a_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(sel_onehot))
    else $error("more than one cell selected");

  // an insert adds exactly one entry
  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_insert |=> $countones(cell_valid) == $past($countones(cell_valid)) + 1)
    else $error("insert did not add exactly one entry");

  // a remove drops exactly one entry
  a_remove_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.do_remove |=> $countones(cell_valid) + 1 == $past($countones(cell_valid)))
    else $error("remove did not drop exactly one entry");

endmodule
